>>> hw/rtl/gdo_pkg.sv
`default_nettype none
package gdo_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int YEAR_WIDTH   = 16;

    // signed running day count: holds day + offset and day - offset
    localparam int DAY_W = OFFSET_WIDTH + 2;

    localparam int S_FIELDS_W = 2 + 5 + 4 + YEAR_WIDTH + OFFSET_WIDTH;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 5 + 4 + YEAR_WIDTH + 9 + 2;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // input field offsets inside s_tdata
    localparam int S_CMD_LSB   = 0;
    localparam int S_DAY_LSB   = 2;
    localparam int S_MONTH_LSB = 7;
    localparam int S_YEAR_LSB  = 11;
    localparam int S_OFF_LSB   = S_YEAR_LSB + YEAR_WIDTH;

    typedef logic [1:0]              cmd_code_t;
    typedef logic [1:0]              status_t;
    typedef logic [YEAR_WIDTH-1:0]   year_t;
    typedef logic [OFFSET_WIDTH-1:0] offset_t;

    localparam cmd_code_t CMD_ADD   = 2'd0;
    localparam cmd_code_t CMD_SUB   = 2'd1;
    localparam cmd_code_t CMD_CHECK = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_INVALID  = 2'd1;
    localparam status_t ST_BEFORE_1 = 2'd2;
    localparam status_t ST_OVERFLOW = 2'd3;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // x divisible by 25 iff x * inv(25) mod 2^32 <= (2^32 - 1) / 25
    localparam logic [31:0] INV25   = 32'hC28F5C29;
    localparam logic [31:0] BOUND25 = 32'h0A3D70A3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_LEAP,
        DP_APPLY_ADD,
        DP_APPLY_SUB,
        DP_STEP_ADD,
        DP_STEP_SUB,
        DP_SAT_HI,
        DP_SAT_LO,
        DP_INVALID,
        DP_ORD
    } dp_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAP_IN,
        S_CHECK,
        S_STEP,
        S_LEAP_STEP,
        S_LEAP_ORD,
        S_ORD,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic date_ok;
        logic is_add;
        logic is_sub;
        logic add_fits;
        logic sub_fits;
        logic at_dec;
        logic at_jan;
        logic year_max;
        logic year_min;
    } dp_stat_t;

    // gregorian leap rule: 4 | y and (25 does not divide y or 16 | y)
    function automatic logic is_leap(input year_t y);
        logic [31:0] prod;
        logic        div25;
        prod  = 32'(y) * INV25;
        div25 = (prod <= BOUND25);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        idx = m - 4'd1;
        if (m == MONTH_FEB && leap) begin
            return 5'd29;
        end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
            return MONTH_LEN[idx];
        end else begin
            return 5'd0;
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        logic [8:0] base;
        idx  = m - 4'd1;
        base = (m >= MONTH_JAN && m <= MONTH_DEC) ? CUM_DAYS[idx] : 9'd0;
        return base + 9'((leap && m > MONTH_FEB) ? 1 : 0);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gdo_dp.sv
`default_nettype none
module gdo_dp
    import gdo_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire dp_cmd_t             cmd,
    output dp_stat_t                 stat,
    output logic      [M_DATA_W-1:0] m_tdata
);

    cmd_code_t               cmd_reg,   cmd_next;
    logic signed [DAY_W-1:0] day_reg,   day_next;
    logic [3:0]              month_reg, month_next;
    year_t                   year_reg,  year_next;
    offset_t                 off_reg,   off_next;
    logic                    leap_reg,  leap_next;
    logic [8:0]              doy_reg,   doy_next;
    status_t                 status_reg, status_next;
    logic [M_DATA_W-1:0]     out_reg,   out_next;

    logic [4:0]              dim_cur;
    logic [3:0]              month_prev;
    logic [4:0]              dim_prev;
    logic signed [DAY_W-1:0] off_ext;

    assign dim_cur    = days_in(month_reg, leap_reg);
    assign month_prev = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;
    assign dim_prev   = days_in(month_prev, leap_reg);
    assign off_ext    = $signed({2'b00, off_reg});

    always_comb begin
        stat.date_ok  = (day_reg[4:0] != 5'd0) && (month_reg >= MONTH_JAN)
                        && (month_reg <= MONTH_DEC) && (year_reg != '0)
                        && (day_reg[4:0] <= dim_cur);
        stat.is_add   = (cmd_reg == CMD_ADD);
        stat.is_sub   = (cmd_reg == CMD_SUB);
        stat.add_fits = (day_reg <= $signed({{(DAY_W-5){1'b0}}, dim_cur}));
        stat.sub_fits = (day_reg > $signed(DAY_W'(0)));
        stat.at_dec   = (month_reg == MONTH_DEC);
        stat.at_jan   = (month_reg == MONTH_JAN);
        stat.year_max = (year_reg == '1);
        stat.year_min = (year_reg <= year_t'(1));
    end

    always_comb begin
        cmd_next    = cmd_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        off_next    = off_reg;
        leap_next   = leap_reg;
        doy_next    = doy_reg;
        status_next = status_reg;
        out_next    = out_reg;
        unique case (cmd.op)
            DP_NOP: begin
            end
            DP_LOAD: begin
                cmd_next    = s_tdata[S_CMD_LSB +: 2];
                day_next    = $signed({{(DAY_W-5){1'b0}}, s_tdata[S_DAY_LSB +: 5]});
                month_next  = s_tdata[S_MONTH_LSB +: 4];
                year_next   = s_tdata[S_YEAR_LSB +: YEAR_WIDTH];
                off_next    = s_tdata[S_OFF_LSB +: OFFSET_WIDTH];
                status_next = ST_OK;
            end
            DP_LEAP: begin
                leap_next = is_leap(year_reg);
            end
            DP_APPLY_ADD: begin
                day_next = day_reg + off_ext;
            end
            DP_APPLY_SUB: begin
                day_next = day_reg - off_ext;
            end
            DP_STEP_ADD: begin
                day_next = day_reg - $signed({{(DAY_W-5){1'b0}}, dim_cur});
                if (month_reg == MONTH_DEC) begin
                    month_next = MONTH_JAN;
                    year_next  = year_reg + year_t'(1);
                end else begin
                    month_next = month_reg + 4'd1;
                end
            end
            DP_STEP_SUB: begin
                // december needs no leap flag, so the stale flag is harmless here
                day_next   = day_reg + $signed({{(DAY_W-5){1'b0}}, dim_prev});
                month_next = month_prev;
                if (month_reg == MONTH_JAN) begin
                    year_next = year_reg - year_t'(1);
                end
            end
            DP_SAT_HI: begin
                day_next    = $signed(DAY_W'(31));
                month_next  = MONTH_DEC;
                year_next   = '1;
                status_next = ST_OVERFLOW;
            end
            DP_SAT_LO: begin
                day_next    = $signed(DAY_W'(1));
                month_next  = MONTH_JAN;
                year_next   = year_t'(1);
                status_next = ST_BEFORE_1;
            end
            DP_INVALID: begin
                day_next    = '0;
                month_next  = '0;
                year_next   = '0;
                doy_next    = '0;
                status_next = ST_INVALID;
            end
            DP_ORD: begin
                doy_next = days_before(month_reg, leap_reg) + 9'(day_reg[4:0]);
            end
            default: begin
            end
        endcase
        if (cmd.out_load) begin
            out_next = M_DATA_W'({status_reg, doy_reg, year_reg, month_reg, day_reg[4:0]});
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        day_reg    <= day_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
        off_reg    <= off_next;
        leap_reg   <= leap_next;
        doy_reg    <= doy_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign m_tdata = out_reg;

endmodule
`default_nettype wire

>>> hw/rtl/gdo_ctrl.sv
`default_nettype none
module gdo_ctrl
    import gdo_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = DP_NOP;
        cmd.out_load = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_LEAP_IN;
                end
            end
            S_LEAP_IN: begin
                cmd.op     = DP_LEAP;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                priority if (!stat.date_ok) begin
                    cmd.op     = DP_INVALID;
                    state_next = S_FINISH;
                end else if (stat.is_add) begin
                    cmd.op     = DP_APPLY_ADD;
                    state_next = S_STEP;
                end else if (stat.is_sub) begin
                    cmd.op     = DP_APPLY_SUB;
                    state_next = S_STEP;
                end else begin
                    state_next = S_ORD;
                end
            end
            S_STEP: begin
                // one month per cycle; a year change adds an S_LEAP_STEP to refresh the leap flag
                if (stat.is_add) begin
                    priority if (stat.add_fits) begin
                        state_next = S_ORD;
                    end else if (stat.at_dec && stat.year_max) begin
                        cmd.op     = DP_SAT_HI;
                        state_next = S_LEAP_ORD;
                    end else begin
                        cmd.op     = DP_STEP_ADD;
                        state_next = stat.at_dec ? S_LEAP_STEP : S_STEP;
                    end
                end else begin
                    priority if (stat.sub_fits) begin
                        state_next = S_ORD;
                    end else if (stat.at_jan && stat.year_min) begin
                        cmd.op     = DP_SAT_LO;
                        state_next = S_ORD;
                    end else begin
                        cmd.op     = DP_STEP_SUB;
                        state_next = stat.at_jan ? S_LEAP_STEP : S_STEP;
                    end
                end
            end
            S_LEAP_STEP: begin
                cmd.op     = DP_LEAP;
                state_next = S_STEP;
            end
            S_LEAP_ORD: begin
                cmd.op     = DP_LEAP;
                state_next = S_ORD;
            end
            S_ORD: begin
                cmd.op     = DP_ORD;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule
`default_nettype wire

>>> hw/rtl/gregorian_date_offset.sv
`default_nettype none
// Gregorian date offset: adds a day count to a date, subtracts it, or only checks the date,
// and returns the resulting date, its ordinal day within the year and a status
// (ok, invalid input, before year one, year overflow). An add or subtract item passes through
// S_IDLE, S_LEAP_IN, S_CHECK, S_STEP, S_ORD and S_FINISH (check only skips S_STEP, and an
// invalid date goes from S_CHECK to S_FINISH); S_STEP steps one month at a time, with a pass
// through S_LEAP_STEP at each year boundary crossed. One item is worked at a time; a new
// item is taken as soon as the previous result sits in the output register, and the next
// result waits until that register has been taken.
module gregorian_date_offset
    import gdo_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // cmd[1:0], in_day[6:2], in_month[10:7], in_year[26:11], offset_days[42:27], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // out_day[4:0], out_month[8:5], out_year[24:9], day_of_year[33:25], status[35:34], zero pad
    output logic      [M_DATA_W-1:0] m_tdata
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    gdo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    gdo_dp u_dp (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire
